>>> hw/rtl/ed_pkg.sv
`timescale 1ns / 1ps

package ed_pkg;

  localparam int MAX_LEN_DEF = 64;

  localparam int OP_W   = 2;
  localparam int CH_W   = 8;
  localparam int DIST_W = 7;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

  // largest distance the result field can carry
  localparam int DIST_SAT = 127;

  // control part of a token travelling down the cell chain
  typedef struct packed {
    logic vld;
    logic rpt;  // 1: report token, 0: query character
    logic ovf;  // overflow flag carried by a report token
  } tok_ctl_t;

endpackage

>>> hw/rtl/ed_if.sv
`timescale 1ns / 1ps

interface ed_in_if;
  logic                      valid;
  logic                      ready;
  logic [ed_pkg::OP_W-1:0]   op;
  logic [ed_pkg::CH_W-1:0]   ch;

  modport source (output valid, output op, output ch, input ready);
  modport sink   (input valid, input op, input ch, output ready);
endinterface

interface ed_out_if;
  logic                      valid;
  logic                      ready;
  logic [ed_pkg::DIST_W-1:0] distance;
  logic                      overflow;

  modport source (output valid, output distance, output overflow, input ready);
  modport sink   (input valid, input distance, input overflow, output ready);
endinterface

>>> hw/rtl/ed_cell.sv
`timescale 1ns / 1ps

module ed_cell #(
  parameter int DW  = 7,
  parameter int IDX = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        wr_en,
  input  logic [DW-1:0]               wr_idx,
  input  logic [ed_pkg::CH_W-1:0]     wr_ch,
  input  ed_pkg::tok_ctl_t            in_ctl,
  input  logic [ed_pkg::CH_W-1:0]     in_ch,
  input  logic [DW-1:0]               in_a,
  input  logic [DW-1:0]               in_b,
  output ed_pkg::tok_ctl_t            out_ctl,
  output logic [ed_pkg::CH_W-1:0]     out_ch,
  output logic [DW-1:0]               out_a,
  output logic [DW-1:0]               out_b
);

  localparam logic [DW-1:0] MY_IDX  = DW'(IDX);
  localparam logic [DW-1:0] MY_SLOT = DW'(IDX - 1);

  logic [ed_pkg::CH_W-1:0] ref_ch_r;
  logic [DW-1:0]           dist_r, dist_nxt;
  ed_pkg::tok_ctl_t        ctl_r, ctl_nxt;
  logic [ed_pkg::CH_W-1:0] tch_r;
  logic [DW-1:0]           a_r, a_nxt;
  logic [DW-1:0]           b_r, b_nxt;

  logic [DW:0] above1, left1, diag_sub, best;

  // in_a: new value of the cell to the left, in_b: its old value (diagonal)
  always_comb begin
    above1   = {1'b0, dist_r} + (DW+1)'(1);
    left1    = {1'b0, in_a} + (DW+1)'(1);
    diag_sub = {1'b0, in_b} + (DW+1)'(ref_ch_r != in_ch);
    best     = above1;
    if (left1 < best) best = left1;
    if (diag_sub < best) best = diag_sub;
  end

  always_comb begin
    dist_nxt = dist_r;
    ctl_nxt  = in_ctl;
    a_nxt    = in_a;
    b_nxt    = in_b;
    if (in_ctl.vld) begin
      if (in_ctl.rpt) begin
        // report token: in_b holds the reference length, in_a the distance
        if (in_b == MY_IDX) a_nxt = dist_r;
        dist_nxt = MY_IDX;
      end else begin
        dist_nxt = best[DW-1:0];
        a_nxt    = best[DW-1:0];
        b_nxt    = dist_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= MY_IDX;
      ctl_r  <= '0;
    end else if (adv) begin
      dist_r <= dist_nxt;
      ctl_r  <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tch_r <= in_ch;
      a_r   <= a_nxt;
      b_r   <= b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_idx == MY_SLOT) ref_ch_r <= wr_ch;
  end

  assign out_ctl = ctl_r;
  assign out_ch  = tch_r;
  assign out_a   = a_r;
  assign out_b   = b_r;

endmodule

>>> hw/rtl/edit_distance_engine.sv
`timescale 1ns / 1ps

// Levenshtein edit distance engine.
// in_chan carries requests {op, ch}: op APPEND adds ch to the reference string
// while no query character is held, op QUERY feeds one character of the second
// string, op REPORT returns the distance and overflow flag on out_chan and
// clears both strings. A string longer than MAX_LEN characters sets the overflow
// flag; the extra characters are dropped. Op 3 is accepted and does nothing.
// Each reference character sits in one of MAX_LEN cells; query characters
// and report requests travel down the chain one cell per cycle, so one
// QUERY or REPORT request is taken every cycle while the chain does not stall.
// An APPEND request is held off until the last query character has passed
// the final cell. A REPORT request passes the token register and every cell
// register before its result is loaded into the output register.
// If out_chan stalls with a result waiting and another report has reached
// the end of the chain, the whole chain and in_chan stall until it drains.
// Reset (rst_n low, synchronous) empties the chain and the output register
// and clears both strings and the overflow flag.

module edit_distance_engine #(
  parameter int MAX_LEN = ed_pkg::MAX_LEN_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  ed_in_if.sink    in_chan,
  ed_out_if.source out_chan
);

  localparam int DW = $clog2(MAX_LEN + 1);
  localparam int SW = (DW > ed_pkg::DIST_W) ? DW : ed_pkg::DIST_W;
  localparam logic [DW-1:0] LEN_MAX = DW'(MAX_LEN);

  logic [DW-1:0] ref_len_r, ref_len_nxt;
  logic [DW-1:0] qcnt_r, qcnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [DW-1:0] qbusy_r, qbusy_nxt;

  ed_pkg::tok_ctl_t        ctl_w [0:MAX_LEN];
  logic [ed_pkg::CH_W-1:0] ch_w  [0:MAX_LEN];
  logic [DW-1:0]           a_w   [0:MAX_LEN];
  logic [DW-1:0]           b_w   [0:MAX_LEN];

  ed_pkg::tok_ctl_t        tok_ctl_r, tok_ctl_nxt;
  logic [ed_pkg::CH_W-1:0] tok_ch_r;
  logic [DW-1:0]           tok_a_r, tok_a_nxt;
  logic [DW-1:0]           tok_b_r, tok_b_nxt;

  logic                        out_vld_r, out_vld_nxt;
  logic [ed_pkg::DIST_W-1:0]   out_dist_r, out_dist_nxt;
  logic                        out_ovf_r;

  logic          adv, in_fire, tail_rpt, wr_en;
  logic [SW-1:0] tail_dist;

  assign tail_rpt = ctl_w[MAX_LEN].vld && ctl_w[MAX_LEN].rpt;
  assign adv      = !(tail_rpt && out_vld_r && !out_chan.ready);
  assign in_chan.ready = adv && (qbusy_r == '0 || in_chan.op != ed_pkg::OP_APPEND);
  assign in_fire  = in_chan.valid && in_chan.ready;

  always_comb begin
    ref_len_nxt = ref_len_r;
    qcnt_nxt    = qcnt_r;
    ovf_nxt     = ovf_r;
    wr_en       = 1'b0;
    tok_ctl_nxt = '0;
    tok_a_nxt   = qcnt_r + DW'(1);
    tok_b_nxt   = qcnt_r;
    qbusy_nxt   = (adv && qbusy_r != '0) ? qbusy_r - DW'(1) : qbusy_r;
    if (in_fire) begin
      unique case (in_chan.op)
        ed_pkg::OP_APPEND: begin
          if (ref_len_r == LEN_MAX) begin
            ovf_nxt = 1'b1;
          end else if (qcnt_r == '0) begin
            wr_en       = 1'b1;
            ref_len_nxt = ref_len_r + DW'(1);
          end
        end
        ed_pkg::OP_QUERY: begin
          if (qcnt_r == LEN_MAX) begin
            ovf_nxt = 1'b1;
          end else begin
            tok_ctl_nxt.vld = 1'b1;
            qcnt_nxt        = qcnt_r + DW'(1);
            qbusy_nxt       = LEN_MAX;
          end
        end
        ed_pkg::OP_REPORT: begin
          tok_ctl_nxt.vld = 1'b1;
          tok_ctl_nxt.rpt = 1'b1;
          tok_ctl_nxt.ovf = ovf_r;
          // empty reference: distance is the query length itself
          tok_a_nxt       = (ref_len_r == '0) ? qcnt_r : '0;
          tok_b_nxt       = ref_len_r;
          ref_len_nxt     = '0;
          qcnt_nxt        = '0;
          ovf_nxt         = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_len_r <= '0;
      qcnt_r    <= '0;
      ovf_r     <= 1'b0;
      qbusy_r   <= '0;
      tok_ctl_r <= '0;
    end else begin
      ref_len_r <= ref_len_nxt;
      qcnt_r    <= qcnt_nxt;
      ovf_r     <= ovf_nxt;
      qbusy_r   <= qbusy_nxt;
      if (adv) tok_ctl_r <= tok_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_ch_r <= in_chan.ch;
      tok_a_r  <= tok_a_nxt;
      tok_b_r  <= tok_b_nxt;
    end
  end

  assign ctl_w[0] = tok_ctl_r;
  assign ch_w[0]  = tok_ch_r;
  assign a_w[0]   = tok_a_r;
  assign b_w[0]   = tok_b_r;

  for (genvar k = 1; k <= MAX_LEN; k++) begin : g_cell
    ed_cell #(
      .DW  (DW),
      .IDX (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .wr_en   (wr_en),
      .wr_idx  (ref_len_r),
      .wr_ch   (in_chan.ch),
      .in_ctl  (ctl_w[k-1]),
      .in_ch   (ch_w[k-1]),
      .in_a    (a_w[k-1]),
      .in_b    (b_w[k-1]),
      .out_ctl (ctl_w[k]),
      .out_ch  (ch_w[k]),
      .out_a   (a_w[k]),
      .out_b   (b_w[k])
    );
  end

  // result register
  assign tail_dist    = SW'(a_w[MAX_LEN]);
  assign out_dist_nxt = (tail_dist > SW'(ed_pkg::DIST_SAT)) ?
                        ed_pkg::DIST_W'(ed_pkg::DIST_SAT) : tail_dist[ed_pkg::DIST_W-1:0];

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv && tail_rpt) out_vld_nxt = 1'b1;
    else if (out_chan.ready) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tail_rpt) begin
      out_dist_r <= out_dist_nxt;
      out_ovf_r  <= ctl_w[MAX_LEN].ovf;
    end
  end

  assign out_chan.valid    = out_vld_r;
  assign out_chan.distance = out_dist_r;
  assign out_chan.overflow = out_ovf_r;

endmodule
